// ===== src/cbr_pkg.sv =====
// Package for the streaming convolution block: widths, register codes, the cell
// control struct and the register clamp helper. Depends on nothing.
package cbr_pkg;

   localparam int DATA_BITS = 16;
   localparam int PROD_BITS = 2 * DATA_BITS;
   localparam int FRAC_BITS = 8;
   localparam int ACC_BITS = 40;
   localparam int WIDX_BITS = 11;
   localparam int COORD_BITS = 6;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam int DEF_MAX_WIDTH = 64;
   localparam int DEF_MAX_KERNEL = 5;
   localparam int DEF_MAX_CHANNELS = 64;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_MAP_WIDTH = 3'd0,
      REG_MAP_HEIGHT = 3'd1,
      REG_KERNEL_SIZE = 3'd2,
      REG_CHANNEL_COUNT = 3'd3,
      REG_BIAS_VALUE = 3'd4,
      REG_RELU_ENABLE = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic active;
   } cell_ctrl_type;

   function automatic logic [15:0] clamp_reg(input logic [15:0] v, input logic [15:0] hi);
      if (v == 16'd0) begin
         return 16'd1;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

endpackage

// ===== src/cbr_if.sv =====
// Handshake interfaces for the request, response and register write channels.
// Depends on cbr_pkg for the payload widths.
interface cbr_req_if
   import cbr_pkg::*;
;
   logic valid;
   logic ready;
   logic kind;
   logic [WIDX_BITS-1:0] weight_index;
   logic signed [DATA_BITS-1:0] data_value;
   modport source(output valid, kind, weight_index, data_value, input ready);
   modport sink(input valid, kind, weight_index, data_value, output ready);
endinterface

interface cbr_rsp_if
   import cbr_pkg::*;
;
   logic valid;
   logic ready;
   logic signed [DATA_BITS-1:0] out_value;
   logic [COORD_BITS-1:0] out_row;
   logic [COORD_BITS-1:0] out_col;
   logic last;
   modport source(output valid, out_value, out_row, out_col, last, input ready);
   modport sink(input valid, out_value, out_row, out_col, last, output ready);
endinterface

interface cbr_csr_if
   import cbr_pkg::*;
;
   logic valid;
   logic ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== src/cbr_cell.sv =====
// One window cell: holds a pixel, passes it to its left neighbor and forms the
// registered product with its weight. Depends on cbr_pkg.
module cbr_cell
   import cbr_pkg::*;
(
   input  logic clock,
   input  cell_ctrl_type ctrl,
   input  logic signed [DATA_BITS-1:0] data_in,
   input  logic signed [DATA_BITS-1:0] weight,
   output logic signed [DATA_BITS-1:0] data_out,
   output logic signed [PROD_BITS-1:0] product
);

   logic signed [DATA_BITS-1:0] pix_ff, pix_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;

   always_comb begin
      pix_in = ctrl.shift ? data_in : pix_ff;
      prod_in = ctrl.active ? PROD_BITS'(pix_ff) * PROD_BITS'(weight) : '0;
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      if (ctrl.load) begin
         prod_ff <= prod_in;
      end
   end

   assign data_out = pix_ff;
   assign product = prod_ff;

endmodule

// ===== src/conv2d_bias_relu_stream.sv =====
// Top level of the streaming convolution with bias and ReLU.
// Depends on cbr_pkg, the interfaces in cbr_if.sv and cbr_cell.
//
// Transactions on req_chan either load one kernel weight (kind 0) or deliver
// one pixel of a padded map (kind 1), in raster order, plane after plane.
// Register writes on csr_chan are always taken; a write to a known register
// restarts the map at row 0, column 0, plane 0, and must only happen while
// the block is idle. Stores keep their contents across writes.
// One transaction is accepted per cycle unless the pipeline stalls. A pixel
// that completes a window on the last plane yields one rsp_chan transaction;
// it passes the row buffer read, the kernel read, the product cells, two
// adder levels, the partial sum update and the output register. The
// pipeline moves as one: while a result waits on rsp_chan, req_chan.ready
// is low unless rsp_chan.ready is high. Reset clears the counters, the
// pipeline valids and the registers to their defaults; kernel, row buffers
// and partial sums are not cleared.
module conv2d_bias_relu_stream
   import cbr_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_KERNEL = DEF_MAX_KERNEL,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)(
   input logic clock,
   input logic reset,
   cbr_req_if.sink req_chan,
   cbr_rsp_if.source rsp_chan,
   cbr_csr_if.sink csr_chan
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int KW = $clog2(MAX_KERNEL + 1);
   localparam int XW = ((CW > KW) ? CW : KW) + 1;
   localparam int RMW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CCW = $clog2(MAX_CHANNELS + 1);
   localparam int K2 = MAX_KERNEL * MAX_KERNEL;
   localparam int KBW = (K2 > 1) ? $clog2(K2) : 1;
   localparam int KS_DEPTH = MAX_CHANNELS * K2;
   localparam int SH = WIDX_BITS + 2 * $clog2(K2) + 1;
   localparam int RECIP = (2 ** SH) / K2 + 1;
   localparam int RW = SH + 1;
   localparam int QW = WIDX_BITS + RW - SH;
   localparam int PIDX_W = 2 * CW;
   localparam int PSUM_DEPTH = 2 ** PIDX_W;
   localparam int TW = ACC_BITS + 2;
   localparam int SAT_HI = 2 ** (DATA_BITS - 1) - 1;
   localparam int SAT_LO = -(2 ** (DATA_BITS - 1));

   typedef struct packed {
      logic valid;
      logic emit;
      logic first;
      logic last;
      logic [CW-1:0] orow;
      logic [CW-1:0] ocol;
   } meta_type;

   // Configuration and position counters.
   logic [WW-1:0] w_ff, w_in, h_ff, h_in;
   logic [KW-1:0] k_ff, k_in;
   logic [CCW-1:0] c_ff, c_in;
   logic signed [DATA_BITS-1:0] bias_ff, bias_in;
   logic relu_ff, relu_in;
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [RMW-1:0] rmod_ff, rmod_in;
   logic [PW-1:0] plane_ff, plane_in;

   logic adv, req_acc, pix_acc, csr_acc, restart;
   logic col_last, row_last, plane_last, win_ok;
   logic [XW-1:0] orow_x, ocol_x;

   // Weight address split.
   logic [WIDX_BITS+RW-1:0] wq_full;
   logic [QW-1:0] wq;
   logic [WIDX_BITS-1:0] wrem;
   logic w_inrange;

   // Stage 1.
   logic p1_pix_ff, p1_wen_ff;
   logic signed [DATA_BITS-1:0] p1_dv_ff;
   logic [KBW-1:0] p1_wbank_ff;
   logic [PW-1:0] p1_waddr_ff, p1_plane_ff;
   logic [RMW-1:0] p1_rmod_ff;
   meta_type m1_ff, m1_in, m2_ff, m3_ff, m4_ff, m5_ff, m6_ff;

   // Memories and read registers.
   logic signed [DATA_BITS-1:0] rbuf [MAX_KERNEL][MAX_WIDTH];
   logic signed [DATA_BITS-1:0] rb_rd_ff [MAX_KERNEL];
   logic signed [DATA_BITS-1:0] kmem [K2][MAX_CHANNELS];
   logic signed [DATA_BITS-1:0] kw_rd_ff [K2];
   logic signed [ACC_BITS-1:0] psum [PSUM_DEPTH];
   logic signed [ACC_BITS-1:0] ps_rd_ff;

   // Cell array.
   cell_ctrl_type cell_ctrl [MAX_KERNEL][MAX_KERNEL];
   logic signed [DATA_BITS-1:0] cell_weight [MAX_KERNEL][MAX_KERNEL];
   logic signed [DATA_BITS-1:0] chain_in [MAX_KERNEL][MAX_KERNEL];
   logic signed [DATA_BITS-1:0] pix_out [MAX_KERNEL][MAX_KERNEL];
   logic signed [PROD_BITS-1:0] prod [MAX_KERNEL][MAX_KERNEL];
   logic signed [DATA_BITS-1:0] newcol [MAX_KERNEL];

   // Adder stages and output.
   logic signed [ACC_BITS-1:0] rowsum_ff [MAX_KERNEL];
   logic signed [ACC_BITS-1:0] rowsum_in [MAX_KERNEL];
   logic signed [ACC_BITS-1:0] total_ff, total_in, acc6_ff, acc_in, addend;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [COORD_BITS-1:0] rsp_row_ff, rsp_col_ff;
   logic rsp_last_ff;

   assign adv = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign req_acc = req_chan.valid && adv;
   assign pix_acc = req_acc && req_chan.kind;
   assign csr_chan.ready = 1'b1;
   assign csr_acc = csr_chan.valid;
   assign restart = csr_acc && (csr_chan.index <= REG_RELU_ENABLE);

   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      k_in = k_ff;
      c_in = c_ff;
      bias_in = bias_ff;
      relu_in = relu_ff;
      if (csr_acc) begin
         unique case (csr_chan.index)
            REG_MAP_WIDTH: begin
               w_in = WW'(clamp_reg(16'(csr_chan.data[6:0]), 16'(MAX_WIDTH)));
            end
            REG_MAP_HEIGHT: begin
               h_in = WW'(clamp_reg(16'(csr_chan.data[6:0]), 16'(MAX_WIDTH)));
            end
            REG_KERNEL_SIZE: begin
               k_in = KW'(clamp_reg(16'(csr_chan.data[2:0]), 16'(MAX_KERNEL)));
            end
            REG_CHANNEL_COUNT: begin
               c_in = CCW'(clamp_reg(16'(csr_chan.data[6:0]), 16'(MAX_CHANNELS)));
            end
            REG_BIAS_VALUE: begin
               bias_in = csr_chan.data;
            end
            REG_RELU_ENABLE: begin
               relu_in = csr_chan.data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      col_last = (XW'(col_ff) + XW'(1)) >= XW'(w_ff);
      row_last = (XW'(row_ff) + XW'(1)) >= XW'(h_ff);
      plane_last = ((CCW + 1)'(plane_ff) + (CCW + 1)'(1)) >= (CCW + 1)'(c_ff);
      win_ok = ((XW'(row_ff) + XW'(1)) >= XW'(k_ff)) && ((XW'(col_ff) + XW'(1)) >= XW'(k_ff));
      orow_x = XW'(row_ff) + XW'(1) - XW'(k_ff);
      ocol_x = XW'(col_ff) + XW'(1) - XW'(k_ff);
      col_in = col_ff;
      row_in = row_ff;
      rmod_in = rmod_ff;
      plane_in = plane_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
         rmod_in = '0;
         plane_in = '0;
      end else if (pix_acc) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in = '0;
               rmod_in = '0;
               plane_in = plane_last ? '0 : plane_ff + PW'(1);
            end else begin
               row_in = row_ff + CW'(1);
               rmod_in = (int'(rmod_ff) == MAX_KERNEL - 1) ? '0 : rmod_ff + RMW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      m1_in.valid = pix_acc && win_ok;
      m1_in.emit = plane_last;
      m1_in.first = (plane_ff == '0);
      m1_in.orow = CW'(orow_x);
      m1_in.ocol = CW'(ocol_x);
      m1_in.last = (orow_x == XW'(h_ff) - XW'(k_ff)) && (ocol_x == XW'(w_ff) - XW'(k_ff));
   end

   always_comb begin
      wq_full = (WIDX_BITS + RW)'(req_chan.weight_index) * (WIDX_BITS + RW)'(RECIP);
      wq = wq_full[WIDX_BITS+RW-1:SH];
      wrem = req_chan.weight_index - WIDX_BITS'(wq * QW'(K2));
      w_inrange = 32'(req_chan.weight_index) < 32'(KS_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= WW'(clamp_reg(16'd34, 16'(MAX_WIDTH)));
         h_ff <= WW'(clamp_reg(16'd34, 16'(MAX_WIDTH)));
         k_ff <= KW'(clamp_reg(16'd3, 16'(MAX_KERNEL)));
         c_ff <= CCW'(clamp_reg(16'd3, 16'(MAX_CHANNELS)));
         bias_ff <= '0;
         relu_ff <= 1'b1;
         col_ff <= '0;
         row_ff <= '0;
         rmod_ff <= '0;
         plane_ff <= '0;
         p1_pix_ff <= 1'b0;
         p1_wen_ff <= 1'b0;
         m1_ff <= '0;
         m2_ff <= '0;
         m3_ff <= '0;
         m4_ff <= '0;
         m5_ff <= '0;
         m6_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_ff <= w_in;
         h_ff <= h_in;
         k_ff <= k_in;
         c_ff <= c_in;
         bias_ff <= bias_in;
         relu_ff <= relu_in;
         col_ff <= col_in;
         row_ff <= row_in;
         rmod_ff <= rmod_in;
         plane_ff <= plane_in;
         if (adv) begin
            p1_pix_ff <= pix_acc;
            p1_wen_ff <= req_acc && !req_chan.kind && w_inrange;
            m1_ff <= m1_in;
            m2_ff <= m1_ff;
            m3_ff <= m2_ff;
            m4_ff <= m3_ff;
            m5_ff <= m4_ff;
            m6_ff <= m5_ff;
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   // Stage 1 payload, row buffers and kernel store.
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_dv_ff <= req_chan.data_value;
         p1_wbank_ff <= KBW'(wrem);
         p1_waddr_ff <= PW'(wq);
         p1_plane_ff <= plane_ff;
         p1_rmod_ff <= rmod_ff;
         for (int b = 0; b < MAX_KERNEL; b++) begin
            rb_rd_ff[b] <= rbuf[b][col_ff];
         end
         for (int b = 0; b < K2; b++) begin
            kw_rd_ff[b] <= kmem[b][p1_plane_ff];
         end
      end
      if (pix_acc) begin
         rbuf[rmod_ff][col_ff] <= req_chan.data_value;
      end
      if (adv && p1_wen_ff) begin
         kmem[p1_wbank_ff][p1_waddr_ff] <= p1_dv_ff;
      end
   end

   always_comb begin
      int bsel;
      bsel = 0;
      for (int a = 0; a < MAX_KERNEL - 1; a++) begin
         bsel = int'(p1_rmod_ff) + a + 1;
         if (bsel >= MAX_KERNEL) begin
            bsel = bsel - MAX_KERNEL;
         end
         newcol[a] = rb_rd_ff[RMW'(bsel)];
      end
      newcol[MAX_KERNEL-1] = p1_dv_ff;
   end

   always_comb begin
      int off;
      int wsel;
      off = MAX_KERNEL - int'(k_ff);
      wsel = 0;
      for (int a = 0; a < MAX_KERNEL; a++) begin
         for (int b = 0; b < MAX_KERNEL; b++) begin
            cell_ctrl[a][b].shift = adv && p1_pix_ff;
            cell_ctrl[a][b].load = adv;
            cell_ctrl[a][b].active = (a >= off) && (b >= off);
            wsel = cell_ctrl[a][b].active ? (a - off) * MAX_KERNEL + (b - off) : 0;
            cell_weight[a][b] = kw_rd_ff[KBW'(wsel)];
         end
      end
   end

   for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_row
      for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_col
         if (b == MAX_KERNEL - 1) begin : g_edge
            assign chain_in[a][b] = newcol[a];
         end else begin : g_inner
            assign chain_in[a][b] = pix_out[a][b+1];
         end
         cbr_cell u_cell (
            .clock(clock),
            .ctrl(cell_ctrl[a][b]),
            .data_in(chain_in[a][b]),
            .weight(cell_weight[a][b]),
            .data_out(pix_out[a][b]),
            .product(prod[a][b])
         );
      end
   end

   // Adder levels and partial sum update.
   always_comb begin
      for (int a = 0; a < MAX_KERNEL; a++) begin
         rowsum_in[a] = '0;
         for (int b = 0; b < MAX_KERNEL; b++) begin
            rowsum_in[a] = rowsum_in[a] + ACC_BITS'(prod[a][b]);
         end
      end
      total_in = '0;
      for (int a = 0; a < MAX_KERNEL; a++) begin
         total_in = total_in + rowsum_ff[a];
      end
      if (m5_ff.first) begin
         addend = '0;
      end else if (m6_ff.valid && m6_ff.orow == m5_ff.orow && m6_ff.ocol == m5_ff.ocol) begin
         addend = acc6_ff;
      end else begin
         addend = ps_rd_ff;
      end
      acc_in = total_ff + addend;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < MAX_KERNEL; a++) begin
            rowsum_ff[a] <= rowsum_in[a];
         end
         total_ff <= total_in;
         ps_rd_ff <= psum[{m4_ff.orow, m4_ff.ocol}];
         acc6_ff <= acc_in;
         if (m5_ff.valid) begin
            psum[{m5_ff.orow, m5_ff.ocol}] <= acc_in;
         end
         rsp_value_ff <= rsp_value_in;
         rsp_row_ff <= COORD_BITS'(m6_ff.orow);
         rsp_col_ff <= COORD_BITS'(m6_ff.ocol);
         rsp_last_ff <= m6_ff.last;
      end
   end

   // Bias, ReLU, rounding to nearest and saturation.
   always_comb begin
      logic signed [TW-1:0] t;
      logic signed [TW-1:0] q;
      t = TW'(acc6_ff) + (TW'(bias_ff) <<< FRAC_BITS);
      if (relu_ff && t < 0) begin
         t = '0;
      end
      t = t + TW'(2 ** (FRAC_BITS - 1));
      q = t >>> FRAC_BITS;
      priority if (q > TW'(SAT_HI)) begin
         rsp_value_in = DATA_BITS'(SAT_HI);
      end else if (q < TW'(SAT_LO)) begin
         rsp_value_in = DATA_BITS'(SAT_LO);
      end else begin
         rsp_value_in = DATA_BITS'(q);
      end
      rsp_valid_in = m6_ff.valid && m6_ff.emit;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_value = rsp_value_ff;
   assign rsp_chan.out_row = rsp_row_ff;
   assign rsp_chan.out_col = rsp_col_ff;
   assign rsp_chan.last = rsp_last_ff;

   a_col_in_map: assert property (@(posedge clock) disable iff (reset)
      XW'(col_ff) < XW'(w_ff) && XW'(row_ff) < XW'(h_ff))
      else $error("position counter outside the map");

   a_rmod_range: assert property (@(posedge clock) disable iff (reset)
      int'(rmod_ff) < MAX_KERNEL)
      else $error("row buffer select out of range");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      restart |=> (col_ff == '0 && row_ff == '0 && plane_ff == '0))
      else $error("register write did not restart the map");

endmodule

// ===== dv/tb_conv2d_bias_relu_stream.sv =====
// Self-checking testbench for conv2d_bias_relu_stream: weight and pixel streams
// with random idling on both sides, checked against an in-bench convolution predictor.
// Depends on cbr_pkg, the interfaces in cbr_if.sv and the block itself.
module tb_conv2d_bias_relu_stream;
   import cbr_pkg::*;

   localparam int KERN_AREA = DEF_MAX_KERNEL * DEF_MAX_KERNEL;
   localparam int KSTORE_DEPTH = DEF_MAX_CHANNELS * KERN_AREA;
   localparam logic KIND_WEIGHT = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_IDX = 3'd6;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      logic kind;
      logic [WIDX_BITS-1:0] widx;
      logic [DATA_BITS-1:0] data;
   } req_item_type;

   typedef struct {
      logic [DATA_BITS-1:0] value;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic last;
   } conv_out_type;

   logic clock;
   logic reset;

   cbr_req_if req_bus();
   cbr_rsp_if rsp_bus();
   cbr_csr_if csr_bus();

   conv2d_bias_relu_stream DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // Predictor state.
   logic [6:0] cfg_width, cfg_height, cfg_channels;
   logic [2:0] cfg_kernel;
   logic [15:0] cfg_bias;
   logic cfg_relu;
   logic signed [DATA_BITS-1:0] kernel_mem [KSTORE_DEPTH];
   logic signed [DATA_BITS-1:0] line_mem [DEF_MAX_KERNEL][DEF_MAX_WIDTH];
   logic [ACC_BITS-1:0] psum_mem [DEF_MAX_WIDTH*DEF_MAX_WIDTH];
   int unsigned pix_col, pix_row, pix_plane;

   req_item_type pending_reqs[$];
   conv_out_type expected_outs[$];
   int error_count;
   int outs_seen;
   int send_gap, recv_stall;
   bit send_idle_on, recv_idle_on;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_BITS-1:0] idx, logic [15:0] d);
      case (idx)
         REG_MAP_WIDTH: cfg_width = d[6:0];
         REG_MAP_HEIGHT: cfg_height = d[6:0];
         REG_KERNEL_SIZE: cfg_kernel = d[2:0];
         REG_CHANNEL_COUNT: cfg_channels = d[6:0];
         REG_BIAS_VALUE: cfg_bias = d;
         REG_RELU_ENABLE: cfg_relu = d[0];
         default: return;
      endcase
      pix_col = 0;
      pix_row = 0;
      pix_plane = 0;
   endfunction

   function automatic void conv_step(req_item_type it);
      int unsigned w, h, k, c, orow, ocol, pidx;
      logic [ACC_BITS-1:0] acc;
      longint prod, t, q;
      conv_out_type o;
      if (it.kind == KIND_WEIGHT) begin
         if (it.widx < KSTORE_DEPTH) kernel_mem[it.widx] = it.data;
         return;
      end
      w = clamp_cfg(cfg_width, DEF_MAX_WIDTH);
      h = clamp_cfg(cfg_height, DEF_MAX_WIDTH);
      k = clamp_cfg(cfg_kernel, DEF_MAX_KERNEL);
      c = clamp_cfg(cfg_channels, DEF_MAX_CHANNELS);
      line_mem[pix_row % DEF_MAX_KERNEL][pix_col] = it.data;
      if (pix_row + 1 >= k && pix_col + 1 >= k) begin
         orow = pix_row + 1 - k;
         ocol = pix_col + 1 - k;
         pidx = orow * DEF_MAX_WIDTH + ocol;
         acc = '0;
         for (int i = 0; i < k; i++) begin
            for (int j = 0; j < k; j++) begin
               prod = longint'(line_mem[(orow + i) % DEF_MAX_KERNEL][ocol + j])
                  * longint'(kernel_mem[pix_plane * KERN_AREA + i * DEF_MAX_KERNEL + j]);
               acc = acc + prod[ACC_BITS-1:0];
            end
         end
         if (pix_plane != 0) acc = acc + psum_mem[pidx];
         psum_mem[pidx] = acc;
         if (pix_plane + 1 >= c) begin
            t = longint'($signed(acc)) + (longint'($signed(cfg_bias)) <<< FRAC_BITS);
            if (cfg_relu && t < 0) t = 0;
            t = t + (longint'(1) <<< (FRAC_BITS - 1));
            q = t >>> FRAC_BITS;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            o.value = q[DATA_BITS-1:0];
            o.row = orow[COORD_BITS-1:0];
            o.col = ocol[COORD_BITS-1:0];
            o.last = (orow == h - k) && (ocol == w - k);
            expected_outs.push_back(o);
         end
      end
      pix_col++;
      if (pix_col >= w) begin
         pix_col = 0;
         pix_row++;
         if (pix_row >= h) begin
            pix_row = 0;
            pix_plane++;
            if (pix_plane >= c) pix_plane = 0;
         end
      end
   endfunction

   // Request driver.
   always @(posedge clock) begin
      req_item_type it;
      logic nxt_valid;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         nxt_valid = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            it.kind = req_bus.kind;
            it.widx = req_bus.weight_index;
            it.data = req_bus.data_value;
            conv_step(it);
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
               it = pending_reqs.pop_front();
               req_bus.kind <= it.kind;
               req_bus.weight_index <= it.widx;
               req_bus.data_value <= it.data;
               nxt_valid = 1'b1;
               send_gap <= send_idle_on ? gap_len() : 0;
            end
         end
         req_bus.valid <= nxt_valid;
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      conv_out_type e;
      int seen;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         seen = outs_seen;
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = seen + 1;
            if (expected_outs.size() == 0) begin
               $display("%0t: unexpected result value=%h row=%0d col=%0d last=%b", $time,
                  rsp_bus.out_value, rsp_bus.out_row, rsp_bus.out_col, rsp_bus.last);
               error_count++;
            end else begin
               e = expected_outs.pop_front();
               if (rsp_bus.out_value !== e.value || rsp_bus.out_row !== e.row
                     || rsp_bus.out_col !== e.col || rsp_bus.last !== e.last) begin
                  $display("%0t: mismatch expected value=%h row=%0d col=%0d last=%b",
                     $time, e.value, e.row, e.col, e.last);
                  $display("%0t:          actual value=%h row=%0d col=%0d last=%b",
                     $time, rsp_bus.out_value, rsp_bus.out_row, rsp_bus.out_col,
                     rsp_bus.last);
                  error_count++;
               end
            end
         end
         if (outs_seen == 60 || outs_seen == 600) begin
            rsp_bus.ready <= 1'b0;
            recv_stall <= 300;
            seen = seen + 1;
         end else if (recv_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            recv_stall <= recv_stall - 1;
         end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            recv_stall <= gap_len();
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         outs_seen <= seen;
      end
   end

   task automatic wait_drained();
      @(posedge clock);
      while (pending_reqs.size() > 0 || req_bus.valid || expected_outs.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [15:0] d);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= d;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      apply_csr(idx, d);
   endtask

   function automatic logic [15:0] rand_q88();
      case ($urandom_range(0, 7))
         0: return 16'($urandom);
         1: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
         2: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
         default: return 16'($signed($urandom_range(0, 800)) - 400);
      endcase
   endfunction

   function automatic logic [15:0] with_noise(logic [15:0] v, int bits);
      logic [15:0] m;
      m = (16'hffff << bits);
      return $urandom_range(0, 1) ? (v | (16'($urandom) & m)) : v;
   endfunction

   task automatic run_map(int unsigned w, int unsigned h, int unsigned k, int unsigned c,
         logic [15:0] bias, logic relu, int unsigned npix, bit pause_mid,
         inout int unsigned items);
      req_item_type it;
      int unsigned cw, ck;
      wait_drained();
      csr_bus.valid <= 1'b0;
      send_idle_on = $urandom_range(0, 3) != 0;
      recv_idle_on = $urandom_range(0, 3) != 0;
      csr_write(REG_MAP_WIDTH, with_noise(16'(w), 7));
      csr_write(REG_MAP_HEIGHT, with_noise(16'(h), 7));
      csr_write(REG_KERNEL_SIZE, with_noise(16'(k), 3));
      csr_write(REG_CHANNEL_COUNT, with_noise(16'(c), 7));
      csr_write(REG_BIAS_VALUE, bias);
      csr_write(REG_RELU_ENABLE, with_noise(16'(relu), 1));
      csr_bus.valid <= 1'b0;
      cw = clamp_cfg(c, DEF_MAX_CHANNELS);
      ck = clamp_cfg(k, DEF_MAX_KERNEL);
      for (int p = 0; p < cw; p++) begin
         for (int i = 0; i < ck; i++) begin
            for (int j = 0; j < ck; j++) begin
               it.kind = KIND_WEIGHT;
               it.widx = WIDX_BITS'(p * KERN_AREA + i * DEF_MAX_KERNEL + j);
               it.data = rand_q88();
               pending_reqs.push_back(it);
               items++;
            end
         end
      end
      for (int n = 0; n < npix; n++) begin
         if (pause_mid && n == npix / 2) wait_drained();
         if ($urandom_range(0, 19) == 0) begin
            it.kind = KIND_WEIGHT;
            it.widx = WIDX_BITS'($urandom_range(0, 2047));
            if ($urandom_range(0, 1)) begin
               it.widx = WIDX_BITS'($urandom_range(0, cw * KERN_AREA - 1));
            end
            it.data = rand_q88();
            pending_reqs.push_back(it);
            if (it.widx < KSTORE_DEPTH) items++;
         end
         it.kind = KIND_PIXEL;
         it.widx = WIDX_BITS'($urandom_range(0, 2047));
         it.data = rand_q88();
         pending_reqs.push_back(it);
         items++;
      end
   endtask

   initial begin
      int unsigned items, w, h, k, c, plane_px;
      req_item_type it;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_WEIGHT;
      req_bus.weight_index = '0;
      req_bus.data_value = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_MAP_WIDTH;
      csr_bus.data = '0;
      error_count = 0;
      outs_seen = 0;
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      cfg_width = 7'd34;
      cfg_height = 7'd34;
      cfg_kernel = 3'd3;
      cfg_channels = 7'd3;
      cfg_bias = '0;
      cfg_relu = 1'b1;
      pix_col = 0;
      pix_row = 0;
      pix_plane = 0;
      items = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: saturating extremes with both bias limits and both ReLU settings.
      run_map(2, 2, 1, 1, 16'h8000, 1'b0, 0, 1'b0, items);
      foreach (pending_reqs[i]) pending_reqs[i].data = 16'h7fff;
      it.kind = KIND_PIXEL;
      it.widx = 11'h7ff;
      it.data = 16'h7fff; pending_reqs.push_back(it);
      it.data = 16'h8000; pending_reqs.push_back(it);
      it.data = 16'h0000; pending_reqs.push_back(it);
      it.data = 16'hffff; pending_reqs.push_back(it);
      it.kind = KIND_WEIGHT;
      it.widx = 11'h7ff;
      it.data = 16'h1234;
      pending_reqs.push_back(it);
      items += 5;
      run_map(2, 2, 1, 1, 16'h7fff, 1'b1, 4, 1'b0, items);
      run_map(3, 3, 5, 1, 16'h0100, 1'b0, 9, 1'b0, items);
      wait_drained();
      csr_write(CSR_UNUSED_IDX, 16'hffff);
      csr_bus.valid <= 1'b0;

      // Register extremes and clamping.
      run_map(64, 1, 1, 1, rand_q88(), 1'b0, 64, 1'b0, items);
      run_map(127, 5, 5, 1, rand_q88(), 1'b1, 320, 1'b1, items);
      run_map(1, 64, 1, 1, rand_q88(), 1'b0, 64, 1'b0, items);
      run_map(0, 0, 0, 0, rand_q88(), 1'b1, 3, 1'b0, items);
      run_map(1, 1, 1, 127, rand_q88(), 1'b0, 128, 1'b0, items);
      run_map(6, 6, 6, 2, rand_q88(), 1'b1, 72, 1'b0, items);

      while (items < 1750) begin
         w = $urandom_range(1, 10);
         h = $urandom_range(1, 8);
         k = $urandom_range(1, 5);
         c = $urandom_range(1, 4);
         plane_px = clamp_cfg(w, 64) * clamp_cfg(h, 64) * clamp_cfg(c, 64);
         run_map(w, h, k, c, rand_q88(), 1'($urandom_range(0, 1)),
            plane_px * $urandom_range(1, 2) + $urandom_range(0, plane_px),
            $urandom_range(0, 7) == 0, items);
      end

      wait_drained();
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
